// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define EPG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, quiet while reset is asserted
`define EPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/epg_pkg.sv =====
package epg_pkg;

    localparam int COORD_WIDTH_DEF  = 10;
    localparam int RADIUS_WIDTH_DEF = 9;
    localparam int COLOR_WIDTH      = 16;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // microprogram counter
    localparam int UPC_W = 4;

    localparam logic [UPC_W-1:0] UA_IDLE   = UPC_W'(0);
    localparam logic [UPC_W-1:0] UA_START  = UPC_W'(1);
    localparam logic [UPC_W-1:0] UA_ST_RY  = UPC_W'(2);
    localparam logic [UPC_W-1:0] UA_ST_IY  = UPC_W'(3);
    localparam logic [UPC_W-1:0] UA_ST_FIN = UPC_W'(4);
    localparam logic [UPC_W-1:0] UA_SWITCH = UPC_W'(5);
    localparam logic [UPC_W-1:0] UA_SW_YM  = UPC_W'(6);
    localparam logic [UPC_W-1:0] UA_SW_A   = UPC_W'(7);
    localparam logic [UPC_W-1:0] UA_SW_B   = UPC_W'(8);
    localparam logic [UPC_W-1:0] UA_SW_C   = UPC_W'(9);
    localparam logic [UPC_W-1:0] UA_SW_FIN = UPC_W'(10);
    localparam logic [UPC_W-1:0] UA_EMIT   = UPC_W'(11);

    // multiplier operand selects
    typedef enum logic [2:0] {
        OPND_ZERO,
        OPND_RX,
        OPND_RY,
        OPND_RX2,
        OPND_RY2,
        OPND_TX,
        OPND_YM,
        OPND_TMP
    } opnd_t;

    // where the registered product goes
    typedef enum logic [2:0] {
        DST_NONE,
        DST_RX2,
        DST_RY2,
        DST_TMP,
        DST_INIT,
        DST_DEC_LOAD,
        DST_DEC_ADD4,
        DST_DEC_SUB4
    } dst_t;

    // sequencing of the next step
    typedef enum logic [1:0] {
        NX_NEXT,
        NX_JUMP,
        NX_WAIT,
        NX_DISPATCH
    } next_t;

    typedef struct packed {
        opnd_t             a_sel;
        opnd_t             b_sel;
        dst_t              dst;
        logic              set_r2;
        logic              emit;
        next_t             nxt;
        logic [UPC_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic active;
        logic switch_due;
    } dp_stat_t;

    // control store
    function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        w = '{a_sel: OPND_ZERO, b_sel: OPND_ZERO, dst: DST_NONE, set_r2: 1'b0,
              emit: 1'b0, nxt: NX_JUMP, target: UA_IDLE};
        case (addr)
            UA_IDLE:
            begin
                w.nxt = NX_DISPATCH;
            end
            UA_START:
            begin
                w.a_sel = OPND_RX;
                w.b_sel = OPND_RX;
                w.nxt   = NX_NEXT;
            end
            UA_ST_RY:
            begin
                w.a_sel = OPND_RY;
                w.b_sel = OPND_RY;
                w.dst   = DST_RX2;
                w.nxt   = NX_NEXT;
            end
            UA_ST_IY:
            begin
                w.a_sel = OPND_RX2;
                w.b_sel = OPND_RY;
                w.dst   = DST_RY2;
                w.nxt   = NX_NEXT;
            end
            UA_ST_FIN:
            begin
                w.dst = DST_INIT;
            end
            UA_SWITCH:
            begin
                w.a_sel = OPND_TX;
                w.b_sel = OPND_TX;
                w.nxt   = NX_NEXT;
            end
            UA_SW_YM:
            begin
                w.a_sel = OPND_YM;
                w.b_sel = OPND_YM;
                w.dst   = DST_TMP;
                w.nxt   = NX_NEXT;
            end
            UA_SW_A:
            begin
                w.a_sel = OPND_RY2;
                w.b_sel = OPND_TMP;
                w.dst   = DST_TMP;
                w.nxt   = NX_NEXT;
            end
            UA_SW_B:
            begin
                w.a_sel = OPND_RX2;
                w.b_sel = OPND_TMP;
                w.dst   = DST_DEC_LOAD;
                w.nxt   = NX_NEXT;
            end
            UA_SW_C:
            begin
                w.a_sel = OPND_RX2;
                w.b_sel = OPND_RY2;
                w.dst   = DST_DEC_ADD4;
                w.nxt   = NX_NEXT;
            end
            UA_SW_FIN:
            begin
                w.dst    = DST_DEC_SUB4;
                w.set_r2 = 1'b1;
                w.nxt    = NX_NEXT;
            end
            UA_EMIT:
            begin
                w.emit = 1'b1;
                w.nxt  = NX_WAIT;
            end
            default:
            begin
                w.nxt = NX_JUMP;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/epg_dp.sv =====
module epg_dp #(
    parameter int COORD_WIDTH  = epg_pkg::COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = epg_pkg::RADIUS_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  epg_pkg::ctrl_t                      ctrl,
    input  logic                                load,
    input  logic                                fire,
    input  logic [COORD_WIDTH-1:0]              center_col,
    input  logic [COORD_WIDTH-1:0]              center_row,
    input  logic [RADIUS_WIDTH-1:0]             radius_x,
    input  logic [RADIUS_WIDTH-1:0]             radius_y,
    input  logic [epg_pkg::COLOR_WIDTH-1:0]     color,
    output epg_pkg::dp_stat_t                   stat,
    output logic signed [COORD_WIDTH+1:0]       pt_col_plus,
    output logic signed [COORD_WIDTH+1:0]       pt_col_minus,
    output logic signed [COORD_WIDTH+1:0]       pt_row_plus,
    output logic signed [COORD_WIDTH+1:0]       pt_row_minus,
    output logic [epg_pkg::COLOR_WIDTH-1:0]     pt_color,
    output logic                                pt_last
);

    localparam int RW     = RADIUS_WIDTH;
    localparam int X_W    = RW + 1;
    localparam int SQ_W   = 2 * RW;
    localparam int MUL_W  = 2 * RW + 4;
    localparam int PROD_W = 2 * MUL_W;
    localparam int INC_W  = 3 * RW + 3;
    localparam int DEC_W  = PROD_W;
    localparam int OUT_W  = COORD_WIDTH + 2;

    logic                             active_reg, active_next;
    logic                             r2_reg, r2_next;

    logic [COORD_WIDTH-1:0]           cx_reg, cy_reg;
    logic [epg_pkg::COLOR_WIDTH-1:0]  color_reg;
    logic [RW-1:0]                    rx_reg, ry_reg;
    logic [X_W-1:0]                   x_reg, x_next;
    logic [RW-1:0]                    y_reg, y_next;
    logic [SQ_W-1:0]                  rx2_reg, rx2_next;
    logic [SQ_W-1:0]                  ry2_reg, ry2_next;
    logic [INC_W-1:0]                 incx_reg, incx_next;
    logic [INC_W-1:0]                 incy_reg, incy_next;
    logic signed [DEC_W-1:0]          dec_reg, dec_next;
    logic [MUL_W-1:0]                 tmp_reg, tmp_next;
    logic [PROD_W-1:0]                prod_reg, prod_next;

    logic [MUL_W-1:0]                 opa, opb;
    logic [RW-1:0]                    ym_abs;
    logic [INC_W-1:0]                 ix_step, iy_step;
    logic signed [DEC_W-1:0]          ix_s, iy_s, rx2_s, ry2_s, prod_s;
    logic signed [DEC_W-1:0]          delta;
    logic                             dec_neg, dec_pos, x_inc, y_dec, is_last;

    function automatic logic [MUL_W-1:0] pick(
        input epg_pkg::opnd_t sel,
        input logic [RW-1:0]   rx,
        input logic [RW-1:0]   ry,
        input logic [SQ_W-1:0] rx2,
        input logic [SQ_W-1:0] ry2,
        input logic [X_W-1:0]  x,
        input logic [RW-1:0]   ym,
        input logic [MUL_W-1:0] tmp
    );
        logic [MUL_W-1:0] v;
        case (sel)
            epg_pkg::OPND_RX:  v = MUL_W'(rx);
            epg_pkg::OPND_RY:  v = MUL_W'(ry);
            epg_pkg::OPND_RX2: v = MUL_W'(rx2);
            epg_pkg::OPND_RY2: v = MUL_W'(ry2);
            epg_pkg::OPND_TX:  v = MUL_W'({x, 1'b1});
            epg_pkg::OPND_YM:  v = MUL_W'(ym);
            epg_pkg::OPND_TMP: v = tmp;
            default:           v = '0;
        endcase
        return v;
    endfunction

    // |y - 1|; squared it equals (y - 1)^2, also at y zero
    assign ym_abs = (y_reg == '0) ? RW'(1) : (y_reg - RW'(1));

    assign opa       = pick(ctrl.a_sel, rx_reg, ry_reg, rx2_reg, ry2_reg, x_reg, ym_abs, tmp_reg);
    assign opb       = pick(ctrl.b_sel, rx_reg, ry_reg, rx2_reg, ry2_reg, x_reg, ym_abs, tmp_reg);
    assign prod_next = opa * opb;

    assign ix_step = incx_reg + INC_W'({ry2_reg, 1'b0});
    assign iy_step = incy_reg - INC_W'({rx2_reg, 1'b0});
    assign ix_s    = DEC_W'(ix_step);
    assign iy_s    = DEC_W'(iy_step);
    assign rx2_s   = DEC_W'(rx2_reg);
    assign ry2_s   = DEC_W'(ry2_reg);
    assign prod_s  = $signed(prod_reg);

    assign dec_neg = dec_reg[DEC_W-1];
    assign dec_pos = !dec_neg && (dec_reg != '0);
    assign x_inc   = r2_reg ? !dec_pos : 1'b1;
    assign y_dec   = r2_reg ? 1'b1 : !dec_neg;
    assign delta   = (x_inc ? ix_s : DEC_W'(0)) - (y_dec ? iy_s : DEC_W'(0))
                   + (r2_reg ? rx2_s : ry2_s);
    assign is_last = r2_reg && (y_reg == '0);

    always_comb
    begin
        active_next = active_reg;
        r2_next     = r2_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        rx2_next    = rx2_reg;
        ry2_next    = ry2_reg;
        incx_next   = incx_reg;
        incy_next   = incy_reg;
        dec_next    = dec_reg;
        tmp_next    = tmp_reg;

        case (ctrl.dst)
            epg_pkg::DST_RX2:      rx2_next = SQ_W'(prod_reg);
            epg_pkg::DST_RY2:      ry2_next = SQ_W'(prod_reg);
            epg_pkg::DST_TMP:      tmp_next = MUL_W'(prod_reg);
            epg_pkg::DST_DEC_LOAD: dec_next = prod_s;
            epg_pkg::DST_DEC_ADD4: dec_next = dec_reg + (prod_s <<< 2);
            epg_pkg::DST_DEC_SUB4: dec_next = dec_reg - (prod_s <<< 2);
            epg_pkg::DST_INIT:
            begin
                x_next      = '0;
                y_next      = ry_reg;
                incx_next   = '0;
                incy_next   = INC_W'(prod_reg << 1);
                dec_next    = (ry2_s <<< 2) + rx2_s - (prod_s <<< 2);
                r2_next     = 1'b0;
                active_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (ctrl.set_r2)
        begin
            r2_next = 1'b1;
        end

        // one midpoint step after the point set goes out
        if (fire)
        begin
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                dec_next = dec_reg + (delta <<< 2);
                if (x_inc)
                begin
                    x_next    = x_reg + X_W'(1);
                    incx_next = ix_step;
                end
                if (y_dec)
                begin
                    y_next    = y_reg - RW'(1);
                    incy_next = iy_step;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            r2_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            r2_reg     <= r2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cx_reg    <= center_col;
            cy_reg    <= center_row;
            color_reg <= color;
            rx_reg    <= radius_x;
            ry_reg    <= radius_y;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        rx2_reg  <= rx2_next;
        ry2_reg  <= ry2_next;
        incx_reg <= incx_next;
        incy_reg <= incy_next;
        dec_reg  <= dec_next;
        tmp_reg  <= tmp_next;
        prod_reg <= prod_next;
    end

    assign stat.active     = active_reg;
    assign stat.switch_due = !r2_reg && !(incx_reg < incy_reg);

    assign pt_col_plus  = OUT_W'(cx_reg) + OUT_W'(x_reg);
    assign pt_col_minus = OUT_W'(cx_reg) - OUT_W'(x_reg);
    assign pt_row_plus  = OUT_W'(cy_reg) + OUT_W'(y_reg);
    assign pt_row_minus = OUT_W'(cy_reg) - OUT_W'(y_reg);
    assign pt_color     = color_reg;
    assign pt_last      = is_last;

endmodule

// ===== hw/rtl/ellipse_point_generator.sv =====
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------------
// input    | in_valid / in_ready  | cmd, center_col, center_row, radius_x, radius_y, color
// output   | out_valid / out_ready| col_plus, col_minus, row_plus, row_minus,
//          |                      | point_color, last
//
// an advance is accepted by the idle word, then the emit step outputs and steps
// the advance that leaves region one first runs six microcode steps that form
// the region-two decision on the shared multiplier before the emit step
// a start runs three squares/products on the multiplier, then init;
// an advance with no ellipse active gives nothing
// reset clears the microprogram counter, the walk's active flag and the output
// valid flag; a stalled output holds only the emit step, new inputs wait behind it

module ellipse_point_generator #(
    parameter int COORD_WIDTH  = epg_pkg::COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = epg_pkg::RADIUS_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [COORD_WIDTH-1:0]              center_col,
    input  logic [COORD_WIDTH-1:0]              center_row,
    input  logic [RADIUS_WIDTH-1:0]             radius_x,
    input  logic [RADIUS_WIDTH-1:0]             radius_y,
    input  logic [epg_pkg::COLOR_WIDTH-1:0]     color,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_WIDTH+1:0]       col_plus,
    output logic signed [COORD_WIDTH+1:0]       col_minus,
    output logic signed [COORD_WIDTH+1:0]       row_plus,
    output logic signed [COORD_WIDTH+1:0]       row_minus,
    output logic [epg_pkg::COLOR_WIDTH-1:0]     point_color,
    output logic                                last
);

    localparam int OUT_W = COORD_WIDTH + 2;

    // microprogram counter and the control word it selects
    logic [epg_pkg::UPC_W-1:0]        upc_reg, upc_next;
    epg_pkg::ctrl_t                   cw;
    epg_pkg::dp_stat_t                stat;

    logic                             in_fire;
    logic                             slot_free;
    logic                             emit_fire;
    logic                             load;

    // point set from the datapath, before the step
    logic signed [OUT_W-1:0]          pt_col_plus, pt_col_minus;
    logic signed [OUT_W-1:0]          pt_row_plus, pt_row_minus;
    logic [epg_pkg::COLOR_WIDTH-1:0]  pt_color;
    logic                             pt_last;

    // output register
    logic                             out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]          col_plus_reg, col_minus_reg;
    logic signed [OUT_W-1:0]          row_plus_reg, row_minus_reg;
    logic [epg_pkg::COLOR_WIDTH-1:0]  color_reg;
    logic                             last_reg;

    assign cw = epg_pkg::ucode_rom(upc_reg);

    // input transactions are taken only by the idle word
    assign in_ready  = (cw.nxt == epg_pkg::NX_DISPATCH);
    assign in_fire   = in_valid && in_ready;
    assign load      = in_fire && (cmd == epg_pkg::CMD_START);

    // emit step proceeds when the output register is empty or draining
    assign slot_free = !out_valid_reg || out_ready;
    assign emit_fire = cw.emit && slot_free;

    // sequencer: dispatch picks the program for the accepted transaction
    always_comb
    begin
        upc_next = upc_reg;
        case (cw.nxt)
            epg_pkg::NX_NEXT:
            begin
                upc_next = upc_reg + epg_pkg::UPC_W'(1);
            end
            epg_pkg::NX_JUMP:
            begin
                upc_next = cw.target;
            end
            epg_pkg::NX_WAIT:
            begin
                if (emit_fire)
                begin
                    upc_next = cw.target;
                end
            end
            epg_pkg::NX_DISPATCH:
            begin
                if (in_fire)
                begin
                    if (cmd == epg_pkg::CMD_START)
                    begin
                        upc_next = epg_pkg::UA_START;
                    end
                    else if (!stat.active)
                    begin
                        upc_next = epg_pkg::UA_IDLE;      // advance with nothing to walk
                    end
                    else if (stat.switch_due)
                    begin
                        upc_next = epg_pkg::UA_SWITCH;    // form the region-two decision
                    end
                    else
                    begin
                        upc_next = epg_pkg::UA_EMIT;
                    end
                end
            end
            default:
            begin
                upc_next = epg_pkg::UA_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= epg_pkg::UA_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload of the output transaction, captured on the emit step
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            col_plus_reg  <= pt_col_plus;
            col_minus_reg <= pt_col_minus;
            row_plus_reg  <= pt_row_plus;
            row_minus_reg <= pt_row_minus;
            color_reg     <= pt_color;
            last_reg      <= pt_last;
        end
    end

    epg_dp #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (cw),
        .load         (load),
        .fire         (emit_fire),
        .center_col   (center_col),
        .center_row   (center_row),
        .radius_x     (radius_x),
        .radius_y     (radius_y),
        .color        (color),
        .stat         (stat),
        .pt_col_plus  (pt_col_plus),
        .pt_col_minus (pt_col_minus),
        .pt_row_plus  (pt_row_plus),
        .pt_row_minus (pt_row_minus),
        .pt_color     (pt_color),
        .pt_last      (pt_last)
    );

    assign out_valid   = out_valid_reg;
    assign col_plus    = col_plus_reg;
    assign col_minus   = col_minus_reg;
    assign row_plus    = row_plus_reg;
    assign row_minus   = row_minus_reg;
    assign point_color = color_reg;
    assign last        = last_reg;

endmodule

// ===== hw/rtl/epg_chk.sv =====
`include "assert_macros.svh"

module epg_chk #(
    parameter int COORD_WIDTH  = epg_pkg::COORD_WIDTH_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                cmd,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [COORD_WIDTH+1:0]       col_plus,
    input logic signed [COORD_WIDTH+1:0]       col_minus,
    input logic signed [COORD_WIDTH+1:0]       row_plus,
    input logic signed [COORD_WIDTH+1:0]       row_minus,
    input logic [epg_pkg::COLOR_WIDTH-1:0]     point_color,
    input logic                                last
);

    // a stalled result holds
    `EPG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(col_plus) && $stable(row_plus) && $stable(point_color) && $stable(last))

    // center plus and minus the same offset keep the same parity
    `EPG_ASSERT_NOW(a_sym_parity, clk, rst_n, out_valid, (col_plus[0] == col_minus[0]) && (row_plus[0] == row_minus[0]))

    // a start transaction produces no result and keeps the input closed
    `EPG_ASSERT_NEXT(a_start_quiet, clk, rst_n, in_valid && in_ready && (cmd == epg_pkg::CMD_START), !in_ready && !$rose(out_valid))

    // the cycle after any input transaction brings no new result yet
    `EPG_ASSERT_NEXT(a_no_early_out, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind ellipse_point_generator epg_chk #(
    .COORD_WIDTH (COORD_WIDTH)
) u_epg_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .col_plus    (col_plus),
    .col_minus   (col_minus),
    .row_plus    (row_plus),
    .row_minus   (row_minus),
    .point_color (point_color),
    .last        (last)
);

// ===== verif/ellipse_point_generator_test.sv =====
module ellipse_point_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = epg_pkg::COORD_WIDTH_DEF;
    localparam int RW = epg_pkg::RADIUS_WIDTH_DEF;
    localparam int OUT_W = CW + 2;

    // receiver hold-off used to back the block up into its input
    localparam int LONG_HOLD = 200;
    // quiet cycles after the last expected point set
    localparam int DRAIN_CYCLES = 40;
    // worst case is roughly 1500 transactions, each with its block steps and two
    // random idle bursts, plus the long hold; this is several times that
    localparam int unsigned CYCLE_LIMIT = 400000;

    // one point set as it leaves the block
    typedef struct packed {
        logic [OUT_W-1:0]                col_plus;
        logic [OUT_W-1:0]                col_minus;
        logic [OUT_W-1:0]                row_plus;
        logic [OUT_W-1:0]                row_minus;
        logic [epg_pkg::COLOR_WIDTH-1:0] point_color;
        logic                            last;
    } point_set_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   cmd;
    logic [CW-1:0]          center_col;
    logic [CW-1:0]          center_row;
    logic [RW-1:0]          radius_x;
    logic [RW-1:0]          radius_y;
    logic [epg_pkg::COLOR_WIDTH-1:0] color;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [OUT_W-1:0] col_plus;
    logic signed [OUT_W-1:0] col_minus;
    logic signed [OUT_W-1:0] row_plus;
    logic signed [OUT_W-1:0] row_minus;
    logic [epg_pkg::COLOR_WIDTH-1:0] point_color;
    logic                   last;

    // point sets still owed by the block, oldest first
    point_set_t expected_points[$];

    // own copy of the walk state, its values 64-bit so wraparound matches the spec
    logic        walk_active = 1'b0;
    logic        second_half = 1'b0;
    logic [63:0] pos_x = '0;
    logic [63:0] pos_y = '0;
    logic [63:0] dec = '0;
    logic [63:0] grad_x = '0;
    logic [63:0] grad_y = '0;
    logic [63:0] rx_sq = '0;
    logic [63:0] ry_sq = '0;
    logic [63:0] ctr_x = '0;
    logic [63:0] ctr_y = '0;
    logic [63:0] ink = '0;

    // idling controls shared by the stimulus and the receiver
    logic        gap_enable = 1'b1;
    logic        stall_enable = 1'b1;
    logic        long_hold_request = 1'b0;

    int unsigned useful_items = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    ellipse_point_generator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .center_col  (center_col),
        .center_row  (center_row),
        .radius_x    (radius_x),
        .radius_y    (radius_y),
        .color       (color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .col_plus    (col_plus),
        .col_minus   (col_minus),
        .row_plus    (row_plus),
        .row_minus   (row_minus),
        .point_color (point_color),
        .last        (last)
    );

    // 20 ns clock, starts low so time zero is not a rising edge
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // midpoint walk predictor, called once per accepted transaction
    task automatic predict_point_set(input logic op, input logic [CW-1:0] cx,
            input logic [CW-1:0] cy, input logic [RW-1:0] rx, input logic [RW-1:0] ry,
            input logic [epg_pkg::COLOR_WIDTH-1:0] rgb);
        point_set_t  ps;
        logic [63:0] tx;
        logic [63:0] ym;
        logic        final_set;
        if (op == epg_pkg::CMD_START)
        begin
            // latch the shape and restart at the top of the ellipse
            ctr_x = 64'(cx);
            ctr_y = 64'(cy);
            ink = 64'(rgb);
            rx_sq = 64'(rx) * 64'(rx);
            ry_sq = 64'(ry) * 64'(ry);
            pos_x = '0;
            pos_y = 64'(ry);
            grad_x = '0;
            grad_y = 2 * rx_sq * 64'(ry);
            dec = 4 * ry_sq + rx_sq - 4 * rx_sq * 64'(ry);
            second_half = 1'b0;
            walk_active = 1'b1;
        end
        else if (walk_active)
        begin
            // leave region one once the x slope catches the y slope
            if (!second_half && !(grad_x < grad_y))
            begin
                tx = 2 * pos_x + 1;
                ym = pos_y - 1;
                dec = ry_sq * tx * tx + 4 * rx_sq * ym * ym - 4 * rx_sq * ry_sq;
                second_half = 1'b1;
            end
            final_set = second_half && (pos_y == 0);
            ps.col_plus = OUT_W'(ctr_x + pos_x);
            ps.col_minus = OUT_W'(ctr_x - pos_x);
            ps.row_plus = OUT_W'(ctr_y + pos_y);
            ps.row_minus = OUT_W'(ctr_y - pos_y);
            ps.point_color = epg_pkg::COLOR_WIDTH'(ink);
            ps.last = final_set;
            expected_points.push_back(ps);
            if (final_set)
            begin
                walk_active = 1'b0;
            end
            else if (second_half)
            begin
                pos_y = pos_y - 1;
                grad_y = grad_y - 2 * rx_sq;
                if (!dec[63] && dec != 0)
                begin
                    dec = dec + 4 * (rx_sq - grad_y);
                end
                else
                begin
                    pos_x = pos_x + 1;
                    grad_x = grad_x + 2 * ry_sq;
                    dec = dec + 4 * (grad_x - grad_y + rx_sq);
                end
            end
            else
            begin
                pos_x = pos_x + 1;
                grad_x = grad_x + 2 * ry_sq;
                if (dec[63])
                begin
                    dec = dec + 4 * (grad_x + ry_sq);
                end
                else
                begin
                    pos_y = pos_y - 1;
                    grad_y = grad_y - 2 * rx_sq;
                    dec = dec + 4 * (grad_x - grad_y + ry_sq);
                end
            end
        end
    endtask

    // offer one transaction and wait for it to be taken; valid is left high so
    // a back-to-back transaction needs no second assignment in the same step
    task automatic send_transaction(input logic op, input logic [CW-1:0] cx,
            input logic [CW-1:0] cy, input logic [RW-1:0] rx, input logic [RW-1:0] ry,
            input logic [epg_pkg::COLOR_WIDTH-1:0] rgb);
        int unsigned gap;
        if (gap_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        center_col <= cx;
        center_row <= cy;
        radius_x <= rx;
        radius_y <= ry;
        color <= rgb;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // advances with no ellipse running are dropped by the block
        if (op == epg_pkg::CMD_START || walk_active)
            useful_items++;
        predict_point_set(op, cx, cy, rx, ry, rgb);
    endtask

    // advance with junk in the shape fields, which must be ignored
    task automatic send_advance();
        send_transaction(epg_pkg::CMD_ADVANCE, CW'($urandom), CW'($urandom), RW'($urandom),
                         RW'($urandom), epg_pkg::COLOR_WIDTH'($urandom));
    endtask

    task automatic run_walk(input int unsigned cap);
        int unsigned n;
        n = 0;
        while (walk_active && n < cap)
        begin
            send_advance();
            n++;
        end
    endtask

    // mostly small radii, a few up to the full range
    function automatic logic [RW-1:0] pick_radius();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 15)
            return RW'($urandom_range(0, 15));
        else if (sel < 19)
            return RW'($urandom_range(16, 63));
        else
            return RW'($urandom_range(64, (1 << RW) - 1));
    endfunction

    // advance with nothing started yet gives no point set
    task automatic test_advance_before_start();
        send_advance();
    endtask

    // zero radii: single last set, vertical run, and a flat ellipse
    task automatic test_degenerate_radii();
        send_transaction(epg_pkg::CMD_START, CW'(100), CW'(200), RW'(0), RW'(0), 16'h1234);
        send_advance();
        send_advance();
        send_transaction(epg_pkg::CMD_START, CW'(300), CW'(400), RW'(0), RW'(3), 16'hA5A5);
        run_walk(10);
        send_transaction(epg_pkg::CMD_START, CW'(50), CW'(60), RW'(5), RW'(0), 16'h5A5A);
        run_walk(10);
    endtask

    // corner centers and full radii: outputs past 1023 and below zero
    task automatic test_field_extremes();
        send_transaction(epg_pkg::CMD_START, {CW{1'b1}}, {CW{1'b1}}, {RW{1'b1}}, {RW{1'b1}},
                         {epg_pkg::COLOR_WIDTH{1'b1}});
        send_advance();
        send_advance();
        send_transaction(epg_pkg::CMD_START, '0, '0, {RW{1'b1}}, {RW{1'b1}}, '0);
        send_advance();
        send_advance();
    endtask

    // start in the middle of a walk, then a small one through the region switch
    task automatic test_restart_and_switch();
        send_transaction(epg_pkg::CMD_START, CW'(500), CW'(500), RW'(9), RW'(7), 16'hF800);
        send_advance();
        send_advance();
        send_transaction(epg_pkg::CMD_START, CW'(700), CW'(20), RW'(4), RW'(2), 16'h07E0);
        run_walk(20);
    endtask

    // receiver stalls for a long stretch while advances keep coming
    task automatic test_output_backpressure();
        send_transaction(epg_pkg::CMD_START, CW'(512), CW'(512), RW'(12), RW'(20),
                         epg_pkg::COLOR_WIDTH'($urandom));
        long_hold_request = 1'b1;
        repeat (30) send_advance();
        run_walk(200);
    endtask

    // mostly complete ellipses with random shape, some cut short, some noise
    task automatic test_random_shapes(input int unsigned count);
        int unsigned goal;
        int unsigned kind;
        goal = useful_items + count;
        while (useful_items < goal)
        begin
            // change idling now and then so some stretches run without gaps
            if ($urandom_range(0, 7) == 0)
            begin
                gap_enable = 1'($urandom_range(0, 1));
                stall_enable = 1'($urandom_range(0, 1));
            end
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                send_transaction(1'($urandom_range(0, 1)), CW'($urandom), CW'($urandom),
                                 pick_radius(), pick_radius(),
                                 epg_pkg::COLOR_WIDTH'($urandom));
            end
            else
            begin
                send_transaction(epg_pkg::CMD_START, CW'($urandom), CW'($urandom),
                                 pick_radius(), pick_radius(),
                                 epg_pkg::COLOR_WIDTH'($urandom));
                if (kind == 1)
                    run_walk($urandom_range(0, 6));
                else
                    run_walk(goal - useful_items);
            end
        end
        gap_enable = 1'b1;
        stall_enable = 1'b1;
    endtask

    // closing stretch at full rate on both sides
    task automatic test_steady_stream();
        gap_enable = 1'b0;
        stall_enable = 1'b0;
        repeat (3)
        begin
            send_transaction(epg_pkg::CMD_START, CW'($urandom), CW'($urandom),
                             RW'($urandom_range(0, 20)), RW'($urandom_range(0, 20)),
                             epg_pkg::COLOR_WIDTH'($urandom));
            run_walk(700);
        end
    endtask

    // stimulus
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= epg_pkg::CMD_START;
        center_col <= '0;
        center_row <= '0;
        radius_x <= '0;
        radius_y <= '0;
        color <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_advance_before_start();
        test_degenerate_radii();
        test_field_extremes();
        test_restart_and_switch();
        test_output_backpressure();
        test_random_shapes(1020);
        test_steady_stream();

        in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
        // anything that shows up now is an extra point set
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin
        int unsigned burst;
        int unsigned held;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                out_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (stall_enable && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 15);
                out_ready <= 1'b0;
                repeat (burst) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // compare every accepted point set with the oldest expectation
    always @(posedge clk)
    begin : point_check
        point_set_t got;
        point_set_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {col_plus, col_minus, row_plus, row_minus, point_color, last};
            if (expected_points.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected point set: col %0d/%0d row %0d/%0d color %h last %b",
                             col_plus, col_minus, row_plus, row_minus, point_color, last);
            end
            else
            begin
                want = expected_points.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("point set mismatch at cycle %0d", cycle_count);
                        $display("  expected col %0d/%0d row %0d/%0d color %h last %b",
                                 $signed(want.col_plus), $signed(want.col_minus),
                                 $signed(want.row_plus), $signed(want.row_minus),
                                 want.point_color, want.last);
                        $display("  actual   col %0d/%0d row %0d/%0d color %h last %b",
                                 col_plus, col_minus, row_plus, row_minus, point_color, last);
                    end
                end
            end
        end
    end

endmodule
